// ===== design/eqlk_pkg.sv =====
// ----------------------------------------------------------------------------
// eqlk_pkg
// Shared constants, codes and the arctangent table for the orientation core.
// ----------------------------------------------------------------------------
`default_nettype none

package eqlk_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    // Widths of the internal datapaths.
    localparam int DW = 33;
    localparam int VW = 38;
    localparam int CW = 34;
    localparam int QW = 18;

    localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;
    localparam logic [14:0] GAIN_HI  = 15'd19898;
    localparam logic [14:0] GAIN_LO  = 15'd15210;

    typedef enum logic
    {
        ACT_EULER = 1'b0,
        ACT_LOOK  = 1'b1
    } action_t;

    typedef struct packed
    {
        logic        action;
        logic [16:0] yaw;
        logic [16:0] pitch;
        logic [16:0] roll;
    } ang_sb_t;

    typedef struct packed
    {
        ang_sb_t              ang;
        logic                 hzero;
        logic signed [DW-1:0] dy;
    } vec1_sb_t;

    typedef struct packed
    {
        ang_sb_t     ang;
        logic        hzero;
        logic        ezero;
        logic [31:0] half_yaw;
    } vec2_sb_t;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:       v = 32'd536870912;
                1:       v = 32'd316933406;
                2:       v = 32'd167458907;
                3:       v = 32'd85004756;
                4:       v = 32'd42667331;
                5:       v = 32'd21354465;
                6:       v = 32'd10679838;
                7:       v = 32'd5340245;
                8:       v = 32'd2670163;
                9:       v = 32'd1335087;
                10:      v = 32'd667544;
                11:      v = 32'd333772;
                12:      v = 32'd166886;
                13:      v = 32'd83443;
                14:      v = 32'd41722;
                15:      v = 32'd20861;
                16:      v = 32'd10430;
                17:      v = 32'd5215;
                18:      v = 32'd2608;
                19:      v = 32'd1304;
                20:      v = 32'd652;
                21:      v = 32'd326;
                22:      v = 32'd163;
                23:      v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/eqlk_front.sv =====
// ----------------------------------------------------------------------------
// eqlk_front
// Direction deltas and their shared normalizing left shift, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlk_front
    import eqlk_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [SB_W-1:0]      in_sb,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [31:0]   tgt_x,
    input  wire logic signed [31:0]   tgt_y,
    input  wire logic signed [31:0]   tgt_z,
    output logic                      out_vld,
    output logic [SB_W-1:0]           out_sb,
    output logic signed [DW-1:0]      out_dx,
    output logic signed [DW-1:0]      out_dy,
    output logic signed [DW-1:0]      out_dz,
    output logic                      out_hzero
);

    logic [3:0]           vld_reg;
    logic [SB_W-1:0]      sb1_reg, sb2_reg, sb3_reg, sb4_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [DW-1:0] dx2_reg, dy2_reg, dz2_reg;
    logic signed [DW-1:0] dx3_reg, dy3_reg, dz3_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg, dz4_reg;
    logic                 hz2_reg, hz3_reg, hz4_reg;
    logic [31:0]          orm_reg;
    logic [4:0]           sh_reg;
    logic signed [DW-1:0] ax, ay, az;
    logic [31:0]          orm_next;
    logic [4:0]           sh_next;

    always_comb
    begin
        ax = dx1_reg[DW-1] ? -dx1_reg : dx1_reg;
        ay = dy1_reg[DW-1] ? -dy1_reg : dy1_reg;
        az = dz1_reg[DW-1] ? -dz1_reg : dz1_reg;
        orm_next = ax[31:0] | ay[31:0] | az[31:0];
    end

    always_comb
    begin
        sh_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (orm_reg[i])
            begin
                sh_next = 5'(31 - i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb1_reg <= in_sb;
            dx1_reg <= DW'(tgt_x) - DW'(pos_x);
            dy1_reg <= DW'(tgt_y) - DW'(pos_y);
            dz1_reg <= DW'(tgt_z) - DW'(pos_z);

            sb2_reg <= sb1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            dz2_reg <= dz1_reg;
            hz2_reg <= (dx1_reg == '0) && (dz1_reg == '0);
            orm_reg <= orm_next;

            sb3_reg <= sb2_reg;
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            dz3_reg <= dz2_reg;
            hz3_reg <= hz2_reg;
            sh_reg  <= sh_next;

            sb4_reg <= sb3_reg;
            dx4_reg <= dx3_reg <<< sh_reg;
            dy4_reg <= dy3_reg <<< sh_reg;
            dz4_reg <= dz3_reg <<< sh_reg;
            hz4_reg <= hz3_reg;
        end
    end

    assign out_vld   = vld_reg[3];
    assign out_sb    = sb4_reg;
    assign out_dx    = dx4_reg;
    assign out_dy    = dy4_reg;
    assign out_dz    = dz4_reg;
    assign out_hzero = hz4_reg;

endmodule

`default_nettype wire

// ===== design/eqlk_vec_cordic.sv =====
// ----------------------------------------------------------------------------
// eqlk_vec_cordic
// Pipelined vectoring CORDIC: atan2 as a binary angle and the scaled magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlk_vec_cordic
    import eqlk_pkg::*;
#(
    parameter int NS   = CORDIC_STAGES_DEF,
    parameter int SB_W = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [SB_W-1:0]      in_sb,
    input  wire logic signed [VW-1:0] in_x,
    input  wire logic signed [VW-1:0] in_y,
    output logic                      out_vld,
    output logic [SB_W-1:0]           out_sb,
    output logic signed [VW-1:0]      out_mag,
    output logic [31:0]               out_ang
);

    logic signed [VW-1:0] x_reg [NS];
    logic signed [VW-1:0] y_reg [NS];
    logic [31:0]          z_reg [NS];
    logic [SB_W-1:0]      sb_reg [NS];
    logic [NS-1:0]        vld_reg;
    logic signed [VW-1:0] x0, y0;
    logic [31:0]          z0;

    always_comb
    begin
        x0 = in_x[VW-1] ? -in_x : in_x;
        y0 = in_x[VW-1] ? -in_y : in_y;
        z0 = in_x[VW-1] ? 32'h80000000 : 32'h0;
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        localparam logic [31:0] ATN = atan_entry(g);
        logic signed [VW-1:0] x_i, y_i, x_next, y_next;
        logic [31:0]          z_i, z_next;
        logic [SB_W-1:0]      sb_i;
        logic                 v_i;

        if (g == 0)
        begin : g_first
            assign x_i  = x0;
            assign y_i  = y0;
            assign z_i  = z0;
            assign sb_i = in_sb;
            assign v_i  = in_vld;
        end
        else
        begin : g_rest
            assign x_i  = x_reg[g-1];
            assign y_i  = y_reg[g-1];
            assign z_i  = z_reg[g-1];
            assign sb_i = sb_reg[g-1];
            assign v_i  = vld_reg[g-1];
        end

        always_comb
        begin
            if (!y_i[VW-1])
            begin
                x_next = x_i + (y_i >>> g);
                y_next = y_i - (x_i >>> g);
                z_next = z_i + ATN;
            end
            else
            begin
                x_next = x_i - (y_i >>> g);
                y_next = y_i + (x_i >>> g);
                z_next = z_i - ATN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]  <= x_next;
                y_reg[g]  <= y_next;
                z_reg[g]  <= z_next;
                sb_reg[g] <= sb_i;
            end
        end
    end

    assign out_vld = vld_reg[NS-1];
    assign out_sb  = sb_reg[NS-1];
    assign out_mag = x_reg[NS-1];
    assign out_ang = z_reg[NS-1];

endmodule

`default_nettype wire

// ===== design/eqlk_rot_cordic.sv =====
// ----------------------------------------------------------------------------
// eqlk_rot_cordic
// Pipelined rotation CORDIC: Q30 cosine and sine of a 32-bit binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlk_rot_cordic
    import eqlk_pkg::*;
#(
    parameter int NS   = CORDIC_STAGES_DEF,
    parameter int SB_W = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [SB_W-1:0]      in_sb,
    input  wire logic [31:0]          in_ang,
    output logic                      out_vld,
    output logic [SB_W-1:0]           out_sb,
    output logic signed [CW-1:0]      out_cos,
    output logic signed [CW-1:0]      out_sin
);

    localparam int ZW = 34;

    logic signed [CW-1:0] x_reg [NS];
    logic signed [CW-1:0] y_reg [NS];
    logic signed [ZW-1:0] z_reg [NS];
    logic [SB_W-1:0]      sb_reg [NS];
    logic [NS-1:0]        flip_reg;
    logic [NS-1:0]        vld_reg;
    logic                 ovld_reg;
    logic [SB_W-1:0]      osb_reg;
    logic signed [CW-1:0] cos_reg, sin_reg;
    logic                 flip0;
    logic [31:0]          a0;
    logic signed [ZW-1:0] z0;

    always_comb
    begin
        flip0 = in_ang[31] ^ in_ang[30];
        a0    = flip0 ? (in_ang ^ 32'h80000000) : in_ang;
        z0    = {{(ZW-32){a0[31]}}, a0};
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        localparam logic [31:0] ATN = atan_entry(g);
        logic signed [CW-1:0] x_i, y_i, x_next, y_next;
        logic signed [ZW-1:0] z_i, z_next;
        logic [SB_W-1:0]      sb_i;
        logic                 v_i, f_i;

        if (g == 0)
        begin : g_first
            assign x_i  = CW'(GAIN_Q30);
            assign y_i  = '0;
            assign z_i  = z0;
            assign sb_i = in_sb;
            assign v_i  = in_vld;
            assign f_i  = flip0;
        end
        else
        begin : g_rest
            assign x_i  = x_reg[g-1];
            assign y_i  = y_reg[g-1];
            assign z_i  = z_reg[g-1];
            assign sb_i = sb_reg[g-1];
            assign v_i  = vld_reg[g-1];
            assign f_i  = flip_reg[g-1];
        end

        always_comb
        begin
            if (!z_i[ZW-1])
            begin
                x_next = x_i - (y_i >>> g);
                y_next = y_i + (x_i >>> g);
                z_next = z_i - ZW'(ATN);
            end
            else
            begin
                x_next = x_i + (y_i >>> g);
                y_next = y_i - (x_i >>> g);
                z_next = z_i + ZW'(ATN);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[g]    <= x_next;
                y_reg[g]    <= y_next;
                z_reg[g]    <= z_next;
                sb_reg[g]   <= sb_i;
                flip_reg[g] <= f_i;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (en)
        begin
            ovld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            osb_reg <= sb_reg[NS-1];
            cos_reg <= flip_reg[NS-1] ? -x_reg[NS-1] : x_reg[NS-1];
            sin_reg <= flip_reg[NS-1] ? -y_reg[NS-1] : y_reg[NS-1];
        end
    end

    assign out_vld = ovld_reg;
    assign out_sb  = osb_reg;
    assign out_cos = cos_reg;
    assign out_sin = sin_reg;

endmodule

`default_nettype wire

// ===== design/eqlk_quat_mul.sv =====
// ----------------------------------------------------------------------------
// eqlk_quat_mul
// Product terms, quaternion sums, rounding and saturation in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module eqlk_quat_mul
    import eqlk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic                 in_degen,
    input  wire logic signed [CW-1:0] cy,
    input  wire logic signed [CW-1:0] sy,
    input  wire logic signed [CW-1:0] cp,
    input  wire logic signed [CW-1:0] sp,
    input  wire logic signed [CW-1:0] cr,
    input  wire logic signed [CW-1:0] sr,
    output logic                      out_vld,
    output logic                      out_degen,
    output logic signed [QW-1:0]      out_w,
    output logic signed [QW-1:0]      out_x,
    output logic signed [QW-1:0]      out_y,
    output logic signed [QW-1:0]      out_z
);

    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        begin
            p = (2*CW)'(a) * (2*CW)'(b);
            p = p + $signed({{(2*CW-30){1'b0}}, 1'b1, 29'd0});
            return p[CW+29:30];
        end
    endfunction

    function automatic logic signed [QW-1:0] out_part(input logic signed [CW:0] v);
        logic signed [CW:0]    r;
        logic signed [CW-14:0] t;
        logic signed [QW-1:0]  q;
        begin
            r = v + (CW+1)'(8192);
            t = r[CW:14];
            if (t < -(CW-13)'(65536))
            begin
                q = -QW'(65536);
            end
            else if (t > (CW-13)'(65536))
            begin
                q = QW'(65536);
            end
            else
            begin
                q = t[QW-1:0];
            end
            return q;
        end
    endfunction

    logic [2:0]           vld_reg;
    logic [2:0]           dg_reg;
    logic signed [CW-1:0] cpcy_reg, spsy_reg, spcy_reg, cpsy_reg, cr_reg, sr_reg;
    logic signed [CW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    logic signed [QW-1:0] w_reg, x_reg, y_reg, z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dg_reg   <= {dg_reg[1:0], in_degen};
            cpcy_reg <= mul_q30(cp, cy);
            spsy_reg <= mul_q30(sp, sy);
            spcy_reg <= mul_q30(sp, cy);
            cpsy_reg <= mul_q30(cp, sy);
            cr_reg   <= cr;
            sr_reg   <= sr;

            m0_reg <= mul_q30(cr_reg, cpcy_reg);
            m1_reg <= mul_q30(sr_reg, spsy_reg);
            m2_reg <= mul_q30(cr_reg, spcy_reg);
            m3_reg <= mul_q30(sr_reg, cpsy_reg);
            m4_reg <= mul_q30(cr_reg, cpsy_reg);
            m5_reg <= mul_q30(sr_reg, spcy_reg);
            m6_reg <= mul_q30(sr_reg, cpcy_reg);
            m7_reg <= mul_q30(cr_reg, spsy_reg);

            w_reg <= out_part((CW+1)'(m0_reg) + (CW+1)'(m1_reg));
            x_reg <= out_part((CW+1)'(m2_reg) + (CW+1)'(m3_reg));
            y_reg <= out_part((CW+1)'(m4_reg) - (CW+1)'(m5_reg));
            z_reg <= out_part((CW+1)'(m6_reg) - (CW+1)'(m7_reg));
        end
    end

    assign out_vld   = vld_reg[2];
    assign out_degen = dg_reg[2];
    assign out_w     = w_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

`default_nettype wire

// ===== design/euler_and_look_at_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// euler_and_look_at_quaternion_core
// Orientation quaternion from yaw, pitch and roll or from an eye and a target.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Word
//  input    in_valid / in_stall    action, three angles, position, target
//  output   out_valid / out_stall  quat_w, quat_x, quat_y, quat_z, degenerate
//
// One word is accepted every cycle while the output is not stalled.
// Words pass through the front end, two vectoring CORDICs, the hypotenuse
// scaling, the rotation CORDICs and the product stages in series.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_and_look_at_quaternion_core
    import eqlk_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 action,
    input  wire logic signed [16:0]   yaw_angle,
    input  wire logic signed [16:0]   pitch_angle,
    input  wire logic signed [16:0]   roll_angle,
    input  wire logic signed [31:0]   pos_x,
    input  wire logic signed [31:0]   pos_y,
    input  wire logic signed [31:0]   pos_z,
    input  wire logic signed [31:0]   tgt_x,
    input  wire logic signed [31:0]   tgt_y,
    input  wire logic signed [31:0]   tgt_z,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [QW-1:0]      quat_w,
    output logic signed [QW-1:0]      quat_x,
    output logic signed [QW-1:0]      quat_y,
    output logic signed [QW-1:0]      quat_z,
    output logic                      degenerate
);

    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    ang_sb_t in_sb;
    assign in_sb = '{action: action, yaw: yaw_angle, pitch: pitch_angle, roll: roll_angle};

    logic                 fr_vld, fr_hz;
    ang_sb_t              fr_sb;
    logic signed [DW-1:0] fr_dx, fr_dy, fr_dz;

    eqlk_front #(.SB_W($bits(ang_sb_t))) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (in_valid),
        .in_sb     (in_sb),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .tgt_x     (tgt_x),
        .tgt_y     (tgt_y),
        .tgt_z     (tgt_z),
        .out_vld   (fr_vld),
        .out_sb    (fr_sb),
        .out_dx    (fr_dx),
        .out_dy    (fr_dy),
        .out_dz    (fr_dz),
        .out_hzero (fr_hz)
    );

    vec1_sb_t             v1_in_sb, v1_sb;
    logic                 v1_vld;
    logic signed [VW-1:0] v1_mag;
    logic [31:0]          v1_ang;

    assign v1_in_sb = '{ang: fr_sb, hzero: fr_hz, dy: fr_dy};

    eqlk_vec_cordic #(.NS(CORDIC_STAGES), .SB_W($bits(vec1_sb_t))) u_vec_azim
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (fr_vld),
        .in_sb   (v1_in_sb),
        .in_x    (VW'(fr_dz)),
        .in_y    (VW'(fr_dx)),
        .out_vld (v1_vld),
        .out_sb  (v1_sb),
        .out_mag (v1_mag),
        .out_ang (v1_ang)
    );

    logic [1:0]  hv_reg;
    vec1_sb_t    h1_sb_reg, h2_sb_reg;
    logic [48:0] phi_reg, plo_reg;
    logic [31:0] hy1_reg, hy2_reg;
    logic [34:0] h_reg;
    logic [33:0] um;
    logic [32:0] azim, yaw33;
    logic [49:0] hsum;

    always_comb
    begin
        um = v1_mag[33:0];
        if (v1_sb.hzero)
        begin
            azim = '0;
        end
        else if (v1_ang > 32'h80000000)
        begin
            azim = {1'b1, v1_ang};
        end
        else
        begin
            azim = {1'b0, v1_ang};
        end
        yaw33 = azim + 33'h080000000;
        hsum  = 50'(phi_reg) + 50'(plo_reg >> 15) + 50'(16384);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= '0;
        end
        else if (en)
        begin
            hv_reg <= {hv_reg[0], v1_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h1_sb_reg <= v1_sb;
            phi_reg   <= 49'(um) * 49'(GAIN_HI);
            plo_reg   <= 49'(um) * 49'(GAIN_LO);
            hy1_reg   <= yaw33[32:1];

            h2_sb_reg <= h1_sb_reg;
            hy2_reg   <= hy1_reg;
            h_reg     <= h1_sb_reg.hzero ? '0 : hsum[49:15];
        end
    end

    vec2_sb_t    v2_in_sb, v2_sb;
    logic        v2_vld;
    logic [31:0] v2_ang;

    assign v2_in_sb = '{ang: h2_sb_reg.ang, hzero: h2_sb_reg.hzero,
                        ezero: (h_reg == '0) && (h2_sb_reg.dy == '0), half_yaw: hy2_reg};

    eqlk_vec_cordic #(.NS(CORDIC_STAGES), .SB_W($bits(vec2_sb_t))) u_vec_elev
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (hv_reg[1]),
        .in_sb   (v2_in_sb),
        .in_x    (VW'({1'b0, h_reg})),
        .in_y    (VW'(h2_sb_reg.dy)),
        .out_vld (v2_vld),
        .out_sb  (v2_sb),
        .out_mag (),
        .out_ang (v2_ang)
    );

    logic        sel_vld_reg, sel_dg_reg;
    logic [31:0] sel_hy_reg, sel_hp_reg, sel_hr_reg;
    logic [32:0] elev;

    always_comb
    begin
        if (v2_sb.ezero)
        begin
            elev = '0;
        end
        else if (v2_ang > 32'h80000000)
        begin
            elev = {1'b1, v2_ang};
        end
        else
        begin
            elev = {1'b0, v2_ang};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_vld_reg <= v2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (action_t'(v2_sb.ang.action) == ACT_LOOK)
            begin
                sel_hy_reg <= v2_sb.half_yaw;
                sel_hp_reg <= elev[32:1];
                sel_hr_reg <= '0;
                sel_dg_reg <= v2_sb.hzero;
            end
            else
            begin
                sel_hy_reg <= {v2_sb.ang.yaw, 15'd0};
                sel_hp_reg <= {v2_sb.ang.pitch, 15'd0};
                sel_hr_reg <= {v2_sb.ang.roll, 15'd0};
                sel_dg_reg <= 1'b0;
            end
        end
    end

    logic                 r_vld, r_dg;
    logic signed [CW-1:0] cy, sy, cp, sp, cr, sr;

    eqlk_rot_cordic #(.NS(CORDIC_STAGES), .SB_W(1)) u_rot_yaw
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sel_vld_reg),
        .in_sb   (sel_dg_reg),
        .in_ang  (sel_hy_reg),
        .out_vld (r_vld),
        .out_sb  (r_dg),
        .out_cos (cy),
        .out_sin (sy)
    );

    eqlk_rot_cordic #(.NS(CORDIC_STAGES), .SB_W(1)) u_rot_pitch
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sel_vld_reg),
        .in_sb   (1'b0),
        .in_ang  (sel_hp_reg),
        .out_vld (),
        .out_sb  (),
        .out_cos (cp),
        .out_sin (sp)
    );

    eqlk_rot_cordic #(.NS(CORDIC_STAGES), .SB_W(1)) u_rot_roll
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sel_vld_reg),
        .in_sb   (1'b0),
        .in_ang  (sel_hr_reg),
        .out_vld (),
        .out_sb  (),
        .out_cos (cr),
        .out_sin (sr)
    );

    eqlk_quat_mul u_quat
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (r_vld),
        .in_degen  (r_dg),
        .cy        (cy),
        .sy        (sy),
        .cp        (cp),
        .sp        (sp),
        .cr        (cr),
        .sr        (sr),
        .out_vld   (out_valid),
        .out_degen (degenerate),
        .out_w     (quat_w),
        .out_x     (quat_x),
        .out_y     (quat_y),
        .out_z     (quat_z)
    );

    a_stall_tie: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow the output stall");

    a_w_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= QW'(65536)) && (quat_w >= -QW'(65536)))
        else $error("quat_w outside the saturation range");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_x <= QW'(65536)) && (quat_x >= -QW'(65536)))
        else $error("quat_x outside the saturation range");

endmodule

`default_nettype wire

// ===== tb/tb_euler_and_look_at_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// tb_euler_and_look_at_quaternion_core
// Self-checking bench for the Euler and look-at orientation quaternion core.
// Directed and random words in both modes are sent under varying idle
// patterns; a bit-accurate predictor computes each quaternion, and a
// scoreboard compares every output word in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_and_look_at_quaternion_core;
    import eqlk_pkg::*;

    localparam int STAGES = 16;
    localparam longint GAIN = 64'sd652032874;
    localparam longint HALF = 64'sd2147483648;
    localparam longint FULL = 64'sd4294967296;

    typedef struct packed
    {
        logic signed [17:0] w;
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic               degen;
    } quat_word_t;

    typedef struct
    {
        action_t            act;
        logic signed [16:0] yaw;
        logic signed [16:0] pitch;
        logic signed [16:0] roll;
        logic signed [31:0] px, py, pz, tx, ty, tz;
    } pose_req_t;

    function automatic longint atan_val(input int i);
        longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        return t[i];
    endfunction

    function automatic void rot_cordic(input logic [31:0] ang, output longint c,
                                       output longint s);
        logic [31:0] a;
        logic flip;
        longint zz, xx, yy, xs, ys;
        a = ang;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip)
            a = a + 32'h80000000;
        zz = a[31] ? longint'(a) - FULL : longint'(a);
        xx = GAIN;
        yy = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            xs = xx >>> i;
            ys = yy >>> i;
            if (zz >= 0)
            begin
                xx -= ys; yy += xs; zz -= atan_val(i);
            end
            else
            begin
                xx += ys; yy -= xs; zz += atan_val(i);
            end
        end
        c = flip ? -xx : xx;
        s = flip ? -yy : yy;
    endfunction

    function automatic logic [31:0] vec_cordic(input longint xi, input longint yi,
                                               output longint mag);
        logic [31:0] zz;
        longint xx, yy, xs, ys;
        xx = xi; yy = yi; zz = 0;
        if (xx < 0)
        begin
            xx = -xx; yy = -yy; zz = 32'h80000000;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            xs = xx >>> i;
            ys = yy >>> i;
            if (yy >= 0)
            begin
                xx += ys; yy -= xs; zz += 32'(atan_val(i));
            end
            else
            begin
                xx -= ys; yy += xs; zz -= 32'(atan_val(i));
            end
        end
        mag = xx;
        return zz;
    endfunction

    function automatic longint signed_ang(input logic [31:0] a);
        return (a > 32'h80000000) ? longint'(a) - FULL : longint'(a);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic signed [17:0] to_q16(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 13)) >>> 14;
        if (r < -65536)
            r = -65536;
        if (r > 65536)
            r = 65536;
        return 18'(r);
    endfunction

    function automatic quat_word_t predict_quat(input pose_req_t q);
        logic [31:0] hy, hp, hr;
        longint cy, sy, cp, sp, cr, sr, cpcy, spsy, spcy, cpsy;
        longint dx, dy, dz, m, azim, elev, mag, h, yaw;
        logic [63:0] um;
        quat_word_t r;
        r.degen = 1'b0;
        if (q.act == ACT_EULER)
        begin
            hy = {q.yaw, 15'd0};
            hp = {q.pitch, 15'd0};
            hr = {q.roll, 15'd0};
        end
        else
        begin
            dx = longint'(q.tx) - longint'(q.px);
            dy = longint'(q.ty) - longint'(q.py);
            dz = longint'(q.tz) - longint'(q.pz);
            m = dx < 0 ? -dx : dx;
            if ((dy < 0 ? -dy : dy) > m)
                m = dy < 0 ? -dy : dy;
            if ((dz < 0 ? -dz : dz) > m)
                m = dz < 0 ? -dz : dz;
            azim = 0; elev = 0; h = 0;
            if (m != 0)
            begin
                while (m < HALF)
                begin
                    m *= 2; dx *= 2; dy *= 2; dz *= 2;
                end
            end
            if (dx == 0 && dz == 0)
                r.degen = 1'b1;
            else
            begin
                azim = signed_ang(vec_cordic(dz, dx, mag));
                um = mag;
                h = longint'((um * (GAIN >> 15) + ((um * (GAIN & 64'h7FFF)) >> 15)
                              + 64'd16384) >> 15);
            end
            if (h != 0 || dy != 0)
                elev = signed_ang(vec_cordic(h, dy, mag));
            yaw = azim + HALF;
            hy = 32'(yaw >> 1);
            hp = 32'(elev >>> 1);
            hr = 0;
        end
        rot_cordic(hy, cy, sy);
        rot_cordic(hp, cp, sp);
        rot_cordic(hr, cr, sr);
        cpcy = qmul(cp, cy);
        spsy = qmul(sp, sy);
        spcy = qmul(sp, cy);
        cpsy = qmul(cp, sy);
        r.w = to_q16(qmul(cr, cpcy) + qmul(sr, spsy));
        r.x = to_q16(qmul(cr, spcy) + qmul(sr, cpsy));
        r.y = to_q16(qmul(cr, cpsy) - qmul(sr, spcy));
        r.z = to_q16(qmul(sr, cpcy) - qmul(cr, spsy));
        return r;
    endfunction

    class quat_scoreboard;
        quat_word_t pending[$];
        int errors = 0;

        function void note_request(pose_req_t q);
            pending.push_back(predict_quat(q));
        endfunction

        function void check_word(quat_word_t got);
            quat_word_t exp_w;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word, actual %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.w !== exp_w.w)
                $display("%0t: quat_w expected %0d actual %0d", $time, exp_w.w, got.w);
            if (got.x !== exp_w.x)
                $display("%0t: quat_x expected %0d actual %0d", $time, exp_w.x, got.x);
            if (got.y !== exp_w.y)
                $display("%0t: quat_y expected %0d actual %0d", $time, exp_w.y, got.y);
            if (got.z !== exp_w.z)
                $display("%0t: quat_z expected %0d actual %0d", $time, exp_w.z, got.z);
            if (got.degen !== exp_w.degen)
                $display("%0t: degenerate expected %0b actual %0b", $time, exp_w.degen,
                         got.degen);
            if (got !== exp_w)
                errors++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic signed [16:0] yaw_angle = '0, pitch_angle = '0, roll_angle = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [17:0] quat_w, quat_x, quat_y, quat_z;
    logic degenerate;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    quat_scoreboard board = new();

    euler_and_look_at_quaternion_core #(.CORDIC_STAGES(STAGES)) DUT
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .yaw_angle(yaw_angle), .pitch_angle(pitch_angle),
        .roll_angle(roll_angle), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tgt_x(tgt_x), .tgt_y(tgt_y), .tgt_z(tgt_z), .out_valid(out_valid),
        .out_stall(out_stall), .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y),
        .quat_z(quat_z), .degenerate(degenerate)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word('{quat_w, quat_x, quat_y, quat_z, degenerate});
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_word(input pose_req_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= q.act;
        yaw_angle <= q.yaw; pitch_angle <= q.pitch; roll_angle <= q.roll;
        pos_x <= q.px; pos_y <= q.py; pos_z <= q.pz;
        tgt_x <= q.tx; tgt_y <= q.ty; tgt_z <= q.tz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(q);
    endtask

    task automatic drain_all();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(3))
            0:       return $signed($urandom_range(255)) - 128;
            1:       return $signed($urandom_range(65536 * 8)) - 65536 * 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic pose_req_t rnd_req();
        pose_req_t q;
        q.act = $urandom_range(1) ? ACT_LOOK : ACT_EULER;
        q.yaw = 17'($urandom); q.pitch = 17'($urandom); q.roll = 17'($urandom);
        q.px = rnd_coord(); q.py = rnd_coord(); q.pz = rnd_coord();
        q.tx = rnd_coord(); q.ty = rnd_coord(); q.tz = rnd_coord();
        if ($urandom_range(9) == 0)
        begin
            q.tx = q.px; q.tz = q.pz;
            if ($urandom_range(1))
                q.ty = q.py;
        end
        return q;
    endfunction

    function automatic pose_req_t mk_look(input logic signed [31:0] px, py, pz,
                                          tx, ty, tz);
        pose_req_t q;
        q = rnd_req();
        q.act = ACT_LOOK;
        q.px = px; q.py = py; q.pz = pz; q.tx = tx; q.ty = ty; q.tz = tz;
        return q;
    endfunction

    function automatic pose_req_t mk_euler(input logic signed [16:0] y, p, r);
        pose_req_t q;
        q = rnd_req();
        q.act = ACT_EULER;
        q.yaw = y; q.pitch = p; q.roll = r;
        return q;
    endfunction

    initial
    begin
        pose_req_t dir_list[$];
        int phase_len;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_list.push_back(mk_euler(0, 0, 0));
        dir_list.push_back(mk_euler(-65536, -65536, -65536));
        dir_list.push_back(mk_euler(65535, 65535, 65535));
        dir_list.push_back(mk_euler(16384, -16384, 32768));
        dir_list.push_back(mk_euler(-32768, 8192, -1));
        dir_list.push_back(mk_euler(1, 49152, -49152));
        dir_list.push_back(mk_look(0, 0, 0, 0, 0, 0));
        dir_list.push_back(mk_look(5, -7, 9, 5, 100, 9));
        dir_list.push_back(mk_look(0, 0, 0, 0, -3, 0));
        dir_list.push_back(mk_look(0, 0, 0, 0, 0, 65536));
        dir_list.push_back(mk_look(0, 0, 0, 0, 0, -65536));
        dir_list.push_back(mk_look(0, 0, 0, 1, 0, 0));
        dir_list.push_back(mk_look(0, 0, 0, -1, 1, 0));
        dir_list.push_back(mk_look(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                   32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        dir_list.push_back(mk_look(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                   32'sh80000000, 32'sh80000000, 32'sh80000000));
        dir_list.push_back(mk_look(0, 0, 0, 0, 32'sh7FFFFFFF, 1));
        dir_list.push_back(mk_look(0, 0, 0, 3, 3, -3));
        dir_list.push_back(mk_look(0, 0, 0, -1, 0, -1));
        foreach (dir_list[i])
            send_word(dir_list[i]);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
            phase_len = 178;
            for (int n = 0; n < phase_len; n++)
            begin
                send_word(rnd_req());
                if (n == phase_len / 2)
                    drain_all();
            end
        end
        drain_all();
        repeat (3 * STAGES + 30) @(posedge clk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
